### src/bclm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_pkg
// Shared widths, codes and control types for the block cache tag manager.
// ----------------------------------------------------------------------------
package bclm_pkg;

    localparam int FILE_W     = 8;
    localparam int SECTOR_W   = 32;
    localparam int OUT_SLOT_W = 4;

    // request operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the request payload
        logic lookup;   // compare tags and register the search results
        logic update;   // apply state changes and load the result register
    } t_dp_cmd;

endpackage

### src/bclm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_req_if / bclm_rsp_if
// Valid/ready channels for cache requests and their results.
// ----------------------------------------------------------------------------
interface bclm_req_if import bclm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [FILE_W-1:0]   file_id;
    logic [SECTOR_W-1:0] sector;
    logic                backing_read_failed;

    modport source (
        output valid, op, file_id, sector, backing_read_failed,
        input  ready
    );
    modport sink (
        input  valid, op, file_id, sector, backing_read_failed,
        output ready
    );
endinterface

interface bclm_rsp_if import bclm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  status;
    logic                  writeback;
    logic [FILE_W-1:0]     victim_file_id;
    logic [SECTOR_W-1:0]   victim_sector;

    modport source (
        output valid, hit, slot, status, writeback, victim_file_id, victim_sector,
        input  ready
    );
    modport sink (
        input  valid, hit, slot, status, writeback, victim_file_id, victim_sector,
        output ready
    );
endinterface

### src/bclm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_ctrl
// Request sequencer: capture, tag lookup, update, with result valid tracking.
// ----------------------------------------------------------------------------
module bclm_ctrl import bclm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // issue commands
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.lookup  = (r_state == S_LOOK);
        o_cmd.update  = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    end

    // advance the sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LOOK;
            S_LOOK: n_state = S_UPD;
            S_UPD:  if (o_cmd.update) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // hold the result until its transfer, reload on update
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/bclm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclm_datapath
// Tag store, parallel tag compare, free/victim selection, recency ranks and
// the result register.
// ----------------------------------------------------------------------------
module bclm_datapath import bclm_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_op,
    input  logic [FILE_W-1:0]     i_file_id,
    input  logic [SECTOR_W-1:0]   i_sector,
    input  logic                  i_failed,
    output logic                  o_hit,
    output logic [OUT_SLOT_W-1:0] o_slot,
    output logic                  o_status,
    output logic                  o_writeback,
    output logic [FILE_W-1:0]     o_victim_file_id,
    output logic [SECTOR_W-1:0]   o_victim_sector
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] OLDEST = SLOT_W'(NUM_SLOTS - 1);

    // slot state
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic [FILE_W-1:0]    r_tag_file   [NUM_SLOTS];
    logic [SECTOR_W-1:0]  r_tag_sector [NUM_SLOTS];
    logic [SLOT_W-1:0]    r_rank       [NUM_SLOTS];

    // captured request
    logic                r_req_op;
    logic [FILE_W-1:0]   r_req_file;
    logic [SECTOR_W-1:0] r_req_sector;
    logic                r_req_failed;

    // lookup results
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_idx;
    logic              r_free_any;
    logic [SLOT_W-1:0] r_free_idx;
    logic [SLOT_W-1:0] r_vict_idx;

    logic [NUM_SLOTS-1:0] n_match;
    logic [SLOT_W-1:0]    n_hit_idx;
    logic [SLOT_W-1:0]    n_free_idx;
    logic [SLOT_W-1:0]    n_vict_idx;

    logic              n_fail;
    logic [SLOT_W-1:0] n_sel;
    logic [SLOT_W-1:0] n_sel_rank;
    logic              n_evict_dirty;

    // latch the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_op     <= i_op;
            r_req_file   <= i_file_id;
            r_req_sector <= i_sector;
            r_req_failed <= i_failed;
        end
    end

    // compare all tags; lowest matching, highest free, and the oldest slot
    always_comb begin
        n_hit_idx  = '0;
        n_free_idx = '0;
        n_vict_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_match[i] = r_valid[i] && (r_tag_file[i] == r_req_file)
                         && (r_tag_sector[i] == r_req_sector);
        end
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (n_match[i]) n_hit_idx = SLOT_W'(i);
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!r_valid[i]) n_free_idx = SLOT_W'(i);
            if (r_rank[i] == OLDEST) n_vict_idx = SLOT_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= |n_match;
            r_hit_idx  <= n_hit_idx;
            r_free_any <= ~&r_valid;
            r_free_idx <= n_free_idx;
            r_vict_idx <= n_vict_idx;
        end
    end

    // pick the target slot
    always_comb begin
        n_fail        = !r_hit && (r_req_op == OP_READ) && r_req_failed;
        n_sel         = r_hit ? r_hit_idx : (r_free_any ? r_free_idx : r_vict_idx);
        n_sel_rank    = r_rank[n_sel];
        n_evict_dirty = !r_hit && !r_free_any && r_dirty[n_sel];
    end

    // update valid and dirty bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else if (i_cmd.update && !n_fail) begin
            r_valid[n_sel] <= 1'b1;
            if (r_hit) begin
                r_dirty[n_sel] <= r_dirty[n_sel] | (r_req_op == OP_WRITE);
            end else begin
                r_dirty[n_sel] <= (r_req_op == OP_WRITE);
            end
        end
    end

    // promote the target; age the others (only the more recent ones on a hit)
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !n_fail) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (SLOT_W'(i) == n_sel) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (!r_hit || (r_rank[i] < n_sel_rank))) begin
                    r_rank[i] <= r_rank[i] + SLOT_W'(1);
                end
            end
            if (!r_hit) begin
                r_tag_file[n_sel]   <= r_req_file;
                r_tag_sector[n_sel] <= r_req_sector;
            end
        end
    end

    // load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_hit       <= r_hit;
            o_slot      <= n_fail ? '0 : OUT_SLOT_W'(n_sel);
            o_status    <= n_fail ? STATUS_FAIL : STATUS_OK;
            o_writeback <= n_evict_dirty && !n_fail;
            o_victim_file_id <= (n_evict_dirty && !n_fail) ? r_tag_file[n_sel] : '0;
            o_victim_sector  <= (n_evict_dirty && !n_fail) ? r_tag_sector[n_sel] : '0;
        end
    end

endmodule

### src/block_cache_lru_tag_manager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cache_lru_tag_manager_core
// Fully associative write-back block cache tag manager with LRU replacement.
// ----------------------------------------------------------------------------
// Each request passes through three steps: the transfer that captures it, a
// lookup step in which all NUM_SLOTS tags are compared in parallel and the
// free and oldest slots are found, and an update step that moves recency
// ranks, tags and dirty bits and loads the result register. The controller's
// three-step sequence takes no new request until the previous one has been
// updated. A request is taken while an earlier result still waits in the
// output register; the update step stalls only if that result has not been
// taken by then. Slots free after reset without any clearing pass. The slot
// field carries the low four bits of the slot index.
// ----------------------------------------------------------------------------
module block_cache_lru_tag_manager_core import bclm_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bclm_req_if.sink    i_req,
    bclm_rsp_if.source  o_rsp
);

    t_dp_cmd w_cmd;

    // sequence control
    bclm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    // tag store and result
    bclm_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_op             (i_req.op),
        .i_file_id        (i_req.file_id),
        .i_sector         (i_req.sector),
        .i_failed         (i_req.backing_read_failed),
        .o_hit            (o_rsp.hit),
        .o_slot           (o_rsp.slot),
        .o_status         (o_rsp.status),
        .o_writeback      (o_rsp.writeback),
        .o_victim_file_id (o_rsp.victim_file_id),
        .o_victim_sector  (o_rsp.victim_sector)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block cache LRU tag manager. A clocked driver
// sends read and write requests from a queue of pending transfers, and a
// clocked monitor compares each result against a cycle-free LRU cache
// predictor that runs on every accepted request. Random gaps and stalls fall
// on both channels.
// ----------------------------------------------------------------------------
module tb;
    import bclm_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_MAX    = 64;

    typedef struct {
        logic                op;
        logic [FILE_W-1:0]   file_id;
        logic [SECTOR_W-1:0] sector;
        logic                failed;
        bit                  drain;   // hold until every result has come back
    } cache_req_t;

    typedef struct {
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  status;
        logic                  writeback;
        logic [FILE_W-1:0]     victim_file_id;
        logic [SECTOR_W-1:0]   victim_sector;
    } cache_rsp_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bclm_req_if req_ch ();
    bclm_rsp_if rsp_ch ();

    block_cache_lru_tag_manager_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // predicted cache contents
    bit                  line_valid  [NUM_SLOTS];
    bit                  line_dirty  [NUM_SLOTS];
    logic [FILE_W-1:0]   line_file   [NUM_SLOTS];
    logic [SECTOR_W-1:0] line_sector [NUM_SLOTS];
    int                  line_age    [NUM_SLOTS];

    cache_req_t pending_q[$];
    cache_rsp_t expected_q[$];
    cache_req_t driven_req;

    logic [FILE_W-1:0]   pool_file   [POOL_MAX];
    logic [SECTOR_W-1:0] pool_sector [POOL_MAX];

    int err_cnt    = 0;
    int cycle_cnt  = 0;
    int gap_left   = 0;
    int stall_left = 0;
    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: tag search, LRU aging and fill/evict for one request
    // ------------------------------------------------------------------------
    function automatic cache_rsp_t cache_access(cache_req_t rq);
        cache_rsp_t r;
        int         i;
        int         s;
        int         old_age;
        bit         found;
        bit         have_free;
        r         = '{default: '0};
        r.status  = STATUS_OK;
        s         = 0;
        found     = 1'b0;
        have_free = 1'b0;
        for (i = 0; i < NUM_SLOTS; i++) begin
            if (!found && line_valid[i] && line_file[i] == rq.file_id &&
                line_sector[i] == rq.sector) begin
                s     = i;
                found = 1'b1;
            end
        end
        if (found) begin
            // hit: age only the slots that were more recent than this one
            r.hit   = 1'b1;
            old_age = line_age[s];
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (i != s && line_valid[i] && line_age[i] < old_age)
                    line_age[i]++;
            end
            line_age[s] = 0;
            if (rq.op == OP_WRITE)
                line_dirty[s] = 1'b1;
        end else if (rq.op == OP_READ && rq.failed) begin
            r.status = STATUS_FAIL;
            s        = 0;
        end else begin
            // take the highest free slot, else evict the oldest
            for (i = NUM_SLOTS - 1; i >= 0; i--) begin
                if (!have_free && !line_valid[i]) begin
                    s         = i;
                    have_free = 1'b1;
                end
            end
            if (!have_free) begin
                s = 0;
                for (i = 1; i < NUM_SLOTS; i++) begin
                    if (line_age[i] > line_age[s])
                        s = i;
                end
                if (line_dirty[s]) begin
                    r.writeback      = 1'b1;
                    r.victim_file_id = line_file[s];
                    r.victim_sector  = line_sector[s];
                end
            end
            line_valid[s]  = 1'b1;
            line_dirty[s]  = (rq.op == OP_WRITE);
            line_file[s]   = rq.file_id;
            line_sector[s] = rq.sector;
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (i != s && line_valid[i])
                    line_age[i]++;
            end
            line_age[s] = 0;
        end
        r.slot = OUT_SLOT_W'(s);
        return r;
    endfunction

    // Mostly short idles, some longer, none while in a burst stretch
    function automatic int idle_len(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_mismatch(string field, logic [SECTOR_W-1:0] exp_val,
                                   logic [SECTOR_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, exp_val, act_val);
            err_cnt++;
        end
    endtask

    task automatic queue_req(logic op, logic [FILE_W-1:0] fid,
                             logic [SECTOR_W-1:0] sec, logic failed, bit drain);
        cache_req_t rq;
        rq.op      = op;
        rq.file_id = fid;
        rq.sector  = sec;
        rq.failed  = failed;
        rq.drain   = drain;
        pending_q.push_back(rq);
    endtask

    // Fill a working set; some tags share a file id or a sector with the
    // previous one so that partial tag matches get exercised
    task automatic build_pool(int n);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r              = $urandom_range(0, 7);
            pool_file[i]   = $urandom_range(0, 255);
            pool_sector[i] = $urandom();
            if (i > 0 && r < 2)
                pool_file[i] = pool_file[i-1];
            else if (i > 0 && r == 2)
                pool_sector[i] = pool_sector[i-1];
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and safe start values
    // ------------------------------------------------------------------------
    always #6 i_clk = ~i_clk;

    initial begin
        req_ch.valid               = 1'b0;
        req_ch.op                  = OP_READ;
        req_ch.file_id             = '0;
        req_ch.sector              = '0;
        req_ch.backing_read_failed = 1'b0;
        rsp_ch.ready               = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: predict on each request transfer, then present the next one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_q.push_back(cache_access(driven_req));
                if ($urandom_range(0, 119) == 0)
                    src_burst = ~src_burst;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].drain && expected_q.size() > 0)) begin
                    driven_req = pending_q.pop_front();
                    req_ch.valid               <= 1'b1;
                    req_ch.op                  <= driven_req.op;
                    req_ch.file_id             <= driven_req.file_id;
                    req_ch.sector              <= driven_req.sector;
                    req_ch.backing_read_failed <= driven_req.failed;
                    gap_left = idle_len(src_burst);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer, then pick the next ready value
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cache_rsp_t exp_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t ns: result with no request outstanding, slot 0x%0h",
                             $time, rsp_ch.slot);
                    err_cnt++;
                end else begin
                    exp_rsp = expected_q.pop_front();
                    report_mismatch("hit", exp_rsp.hit, rsp_ch.hit);
                    report_mismatch("slot", exp_rsp.slot, rsp_ch.slot);
                    report_mismatch("status", exp_rsp.status, rsp_ch.status);
                    report_mismatch("writeback", exp_rsp.writeback, rsp_ch.writeback);
                    report_mismatch("victim_file_id", exp_rsp.victim_file_id,
                                    rsp_ch.victim_file_id);
                    report_mismatch("victim_sector", exp_rsp.victim_sector,
                                    rsp_ch.victim_sector);
                end
                if ($urandom_range(0, 119) == 0)
                    sink_burst = ~sink_burst;
                stall_left = idle_len(sink_burst);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    // Hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int pool_sizes[6];
        int ph;
        int k;
        int idx;
        logic op;
        logic failed;
        pool_sizes = '{10, 18, 24, 40, 14, 64};

        // failed read miss on an empty cache with an all-zero tag; tags are not reset
        queue_req(OP_READ, 8'h00, 32'h0000_0000, 1'b1, 1'b0);
        queue_req(OP_READ, 8'h00, 32'h0000_0000, 1'b0, 1'b0);
        // write miss ignores the failure flag and starts dirty
        queue_req(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // read hit ignores the failure flag, then a write hit dirties it
        queue_req(OP_READ, 8'h00, 32'h0000_0000, 1'b1, 1'b0);
        queue_req(OP_WRITE, 8'h00, 32'h0000_0000, 1'b0, 1'b0);
        // tags matching in one field only
        queue_req(OP_READ, 8'hFF, 32'h0000_0000, 1'b0, 1'b0);
        queue_req(OP_READ, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // fill the remaining slots
        for (k = 0; k < NUM_SLOTS - 4; k++)
            queue_req(k[0] ? OP_WRITE : OP_READ, 8'(k + 1), 32'h8000_0000 | k,
                      1'b0, 1'b0);
        // full cache: dirty victims, then a clean victim
        queue_req(OP_READ, 8'h5A, 32'hA5A5_A5A5, 1'b0, 1'b0);
        queue_req(OP_WRITE, 8'hA5, 32'h5A5A_5A5A, 1'b0, 1'b0);
        queue_req(OP_READ, 8'h7F, 32'h7FFF_FFFF, 1'b0, 1'b0);
        // hit in the middle of the age order, failed miss on a full cache
        queue_req(OP_READ, 8'h06, 32'h8000_0005, 1'b0, 1'b0);
        queue_req(OP_READ, 8'h80, 32'h0000_0001, 1'b1, 1'b0);

        // random phases over working sets of different sizes; each phase
        // starts only once the previous one has fully drained
        for (ph = 0; ph < 6; ph++) begin
            build_pool(pool_sizes[ph]);
            for (k = 0; k < 255; k++) begin
                op     = $urandom_range(0, 1);
                failed = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 82) begin
                    idx = $urandom_range(0, pool_sizes[ph] - 1);
                    queue_req(op, pool_file[idx], pool_sector[idx], failed, k == 0);
                end else begin
                    queue_req(op, 8'($urandom_range(0, 255)), $urandom(), failed, k == 0);
                end
            end
        end

        while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
